### sv/tks_pkg.sv
// tks_pkg: shared types and constants for the table key search block
// field widths, operation and mode codes, register indexes, state encoding
// no dependencies
package tks_pkg;

   // field widths of the request and response words
   localparam int KEY_W      = 32;
   localparam int ENTRY_IDX_W = 8;
   localparam int POS_W      = 8;

   // configuration port
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 9;
   localparam int COUNT_W    = 9;

   localparam logic [CSR_ADDR_W-1:0] REG_SEARCH_MODE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_ENTRY_COUNT = 1'b1;

   // request operation codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // search modes
   localparam logic MODE_LINEAR = 1'b0;
   localparam logic MODE_BINARY = 1'b1;

   // search sequencer states
   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_SCAN      = 5'b00010,
      ST_BIN_ISSUE = 5'b00100,
      ST_BIN_CMP   = 5'b01000,
      ST_FINISH    = 5'b10000
   } state_type;

endpackage

### sv/tks_req_if.sv
// tks_req_if: request channel of the table key search block
// valid/ready handshake carrying one write or search word
// depends on tks_pkg
interface tks_req_if;
   logic                               valid;
   logic                               ready;
   logic                               op;
   logic [tks_pkg::ENTRY_IDX_W-1:0]    entry_index;
   logic [tks_pkg::KEY_W-1:0]          entry_radius;
   logic [tks_pkg::KEY_W-1:0]          search_key;

   modport source (output valid, output op, output entry_index, output entry_radius,
                   output search_key, input ready);
   modport sink (input valid, input op, input entry_index, input entry_radius,
                 input search_key, output ready);
endinterface

### sv/tks_rsp_if.sv
// tks_rsp_if: response channel of the table key search block
// valid/ready handshake carrying found flag and position
// depends on tks_pkg
interface tks_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [tks_pkg::POS_W-1:0]    position;

   modport source (output valid, output found, output position, input ready);
   modport sink (input valid, input found, input position, output ready);
endinterface

### sv/table_key_search_core.sv
// table_key_search_core: lookup table of 32-bit radius keys
//
// Usage: a request word on req_if either writes a key into the table
// (op = write, entry_index, entry_radius) or searches for search_key
// (op = search). Writes give no response; each search gives one response
// word on rsp_if with found and position (position is zero on a miss).
// csr_wr_en/csr_addr/csr_wr_data set search_mode (0 linear first match,
// 1 binary search over an ascending table) and entry_count.
//
// Timing: a write leaves the sequencer idle, so the next word can be taken
// at once. A linear search reads one entry per cycle through the table RAM
// port over the used entries, used = min(entry_count, TABLE_DEPTH); each
// halving step of a binary search issues a RAM read and then a compare.
// One search is in flight at a time.
//
// Reset clears the configuration registers to linear mode and an empty
// table count; the table contents are not cleared and must be written
// before they are searched. A finished response waits in an output register
// while the next request is taken; a search that completes while that
// register is still full holds until the receiver takes the pending word.
module table_key_search_core #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   tks_req_if.sink                             req_if,
   tks_rsp_if.source                           rsp_if,
   input  logic                                csr_wr_en,
   input  logic [tks_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [tks_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = IDX_W + 1;

   // configuration registers
   logic                          search_mode_ff;
   logic [tks_pkg::COUNT_W-1:0]   entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         search_mode_ff <= tks_pkg::MODE_LINEAR;
         entry_count_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_addr)
            tks_pkg::REG_SEARCH_MODE: search_mode_ff <= csr_wr_data[0];
            tks_pkg::REG_ENTRY_COUNT: entry_count_ff <= csr_wr_data[tks_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // entries in use, limited to the table depth
   logic [CNT_W-1:0] used_count;
   always_comb begin
      if (32'(entry_count_ff) > 32'(TABLE_DEPTH)) begin
         used_count = CNT_W'(TABLE_DEPTH);
      end else begin
         used_count = CNT_W'(entry_count_ff);
      end
   end

   // sequencer registers
   tks_pkg::state_type            state_ff, state_in;
   logic [tks_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [CNT_W-1:0]              used_ff, used_in;
   logic [CNT_W-1:0]              issue_ff, issue_in;
   logic [CNT_W-1:0]              lo_ff, lo_in;
   logic [CNT_W-1:0]              hi_ff, hi_in;
   logic                          res_found_ff, res_found_in;
   logic [IDX_W-1:0]              res_pos_ff, res_pos_in;
   logic                          rd_vld_ff;
   logic [IDX_W-1:0]              rd_pos_ff;

   // response output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [tks_pkg::POS_W-1:0]     rsp_pos_ff, rsp_pos_in;

   // table port signals
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic                          rd_en;
   logic [IDX_W-1:0]              rd_addr;
   logic [tks_pkg::KEY_W-1:0]     rd_data;

   logic                          req_take;
   logic [CNT_W:0]                mid_sum;
   logic [CNT_W-1:0]              mid;
   logic [CNT_W-1:0]              rd_pos_next;
   logic [31:0]                   pos_wide;

   assign req_if.ready = (state_ff == tks_pkg::ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;

   // table writes, out-of-range indexes dropped
   assign wr_en   = req_take && (req_if.op == tks_pkg::OP_WRITE)
                    && (32'(req_if.entry_index) < 32'(TABLE_DEPTH));
   assign wr_addr = IDX_W'(req_if.entry_index);

   // binary midpoint of [lo, hi-1]
   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff} - (CNT_W + 1)'(1);
   assign mid         = mid_sum[CNT_W:1];
   assign rd_pos_next = CNT_W'({1'b0, rd_pos_ff}) + CNT_W'(1);

   tks_radius_ram #(
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_if.entry_radius),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      used_in      = used_ff;
      issue_in     = issue_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      rd_en        = 1'b0;
      rd_addr      = issue_ff[IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      pos_wide     = 32'(res_pos_ff);

      case (state_ff)
         tks_pkg::ST_IDLE: begin
            if (req_take && (req_if.op == tks_pkg::OP_SEARCH)) begin
               key_in       = req_if.search_key;
               used_in      = used_count;
               issue_in     = '0;
               lo_in        = '0;
               hi_in        = used_count;
               res_found_in = 1'b0;
               res_pos_in   = '0;
               if (search_mode_ff == tks_pkg::MODE_BINARY) begin
                  state_in = tks_pkg::ST_BIN_ISSUE;
               end else begin
                  state_in = tks_pkg::ST_SCAN;
               end
            end
         end
         tks_pkg::ST_SCAN: begin
            // issue one read per cycle, compare the word read last cycle
            if (issue_ff < used_ff) begin
               rd_en    = 1'b1;
               rd_addr  = issue_ff[IDX_W-1:0];
               issue_in = issue_ff + CNT_W'(1);
            end
            if (used_ff == '0) begin
               state_in = tks_pkg::ST_FINISH;
            end else if (rd_vld_ff) begin
               if (rd_data == key_ff) begin
                  res_found_in = 1'b1;
                  res_pos_in   = rd_pos_ff;
                  state_in     = tks_pkg::ST_FINISH;
               end else if (rd_pos_next == used_ff) begin
                  state_in = tks_pkg::ST_FINISH;
               end
            end
         end
         tks_pkg::ST_BIN_ISSUE: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid[IDX_W-1:0];
               state_in = tks_pkg::ST_BIN_CMP;
            end else begin
               state_in = tks_pkg::ST_FINISH;
            end
         end
         tks_pkg::ST_BIN_CMP: begin
            if (rd_data == key_ff) begin
               res_found_in = 1'b1;
               res_pos_in   = rd_pos_ff;
               state_in     = tks_pkg::ST_FINISH;
            end else if (rd_data < key_ff) begin
               lo_in    = rd_pos_next;
               state_in = tks_pkg::ST_BIN_ISSUE;
            end else begin
               hi_in    = CNT_W'({1'b0, rd_pos_ff});
               state_in = tks_pkg::ST_BIN_ISSUE;
            end
         end
         tks_pkg::ST_FINISH: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_pos_in   = pos_wide[tks_pkg::POS_W-1:0];
               state_in     = tks_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tks_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tks_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_en;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      used_ff      <= used_in;
      issue_ff     <= issue_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      if (rd_en) begin
         rd_pos_ff <= rd_addr;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.found    = rsp_found_ff;
   assign rsp_if.position = rsp_pos_ff;

endmodule

### sv/tks_radius_ram.sv
// tks_radius_ram: single-port-write, single-port-read key table
// synchronous write, registered read
// depends on tks_pkg for the key width
module tks_radius_ram #(
   parameter int DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic [tks_pkg::KEY_W-1:0]       wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [tks_pkg::KEY_W-1:0]       rd_data
);

   logic [tks_pkg::KEY_W-1:0] mem [DEPTH];
   logic [tks_pkg::KEY_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
